### rtl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

    localparam logic [7:0] CONT_MASK  = 8'b1100_0000;
    localparam logic [7:0] CONT_TAG   = 8'b1000_0000;
    localparam logic [7:0] LEAD2_MASK = 8'b1110_0000;
    localparam logic [7:0] LEAD2_TAG  = 8'b1100_0000;
    localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
    localparam logic [7:0] LEAD3_TAG  = 8'b1110_0000;

    localparam logic [15:0] MAX_COUNT_RESET = 16'hFFFF;

    localparam int ADDR_W = 3;
    localparam logic REG_MAX_COUNT = 1'b0;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_end;
    } result_t;

    typedef struct packed {
        logic    wr0;
        logic    wr1;
        result_t res0;
        result_t res1;
    } dec_out_t;

endpackage

### rtl/u8u16_decode.sv
// Byte decoder: sequence state, unit count and result generation.
module u8u16_decode
    import u8u16_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  logic [7:0]  data_byte,
    input  logic [15:0] max_count,
    output dec_out_t    dec_out
);

    logic [1:0]  pend_reg, pend_next;
    logic [15:0] partial_reg, partial_next;
    logic [15:0] units_reg, units_next;
    logic        full_reg, full_next;
    logic        have_unit;
    logic [15:0] unit_val;
    logic [15:0] units_inc;

    always_comb begin
        pend_next    = pend_reg;
        partial_next = partial_reg;
        units_next   = units_reg;
        full_next    = full_reg;
        have_unit    = 1'b0;
        unit_val     = 16'h0000;
        units_inc    = units_reg + 16'd1;
        dec_out      = '0;
        if (fire) begin
            if (data_byte == 8'h00) begin
                if (!full_reg) begin
                    dec_out.wr0  = 1'b1;
                    dec_out.res0 = '{code_unit: 16'h0000, is_end: 1'b1};
                end
                pend_next    = 2'd0;
                partial_next = 16'h0000;
                units_next   = 16'h0000;
                full_next    = 1'b0;
            end else if (!full_reg) begin
                if (pend_reg != 2'd0) begin
                    if ((data_byte & CONT_MASK) == CONT_TAG) begin
                        if (pend_reg == 2'd2) begin
                            partial_next = partial_reg | {4'b0, data_byte[5:0], 6'b0};
                        end else begin
                            partial_next = partial_reg | {10'b0, data_byte[5:0]};
                        end
                        pend_next = pend_reg[1] ? 2'd1 : 2'd0;
                        if (!pend_reg[1]) begin
                            unit_val     = partial_next;
                            have_unit    = 1'b1;
                            partial_next = 16'h0000;
                        end
                    end else begin
                        pend_next    = 2'd0;
                        partial_next = 16'h0000;
                    end
                end else if (data_byte[7] == 1'b0) begin
                    unit_val  = {8'h00, data_byte};
                    have_unit = 1'b1;
                end else if ((data_byte & LEAD2_MASK) == LEAD2_TAG) begin
                    partial_next = {5'b0, data_byte[4:0], 6'b0};
                    pend_next    = 2'd1;
                end else if ((data_byte & LEAD3_MASK) == LEAD3_TAG) begin
                    partial_next = {data_byte[3:0], 12'h000};
                    pend_next    = 2'd2;
                end
                if (have_unit) begin
                    dec_out.wr0  = 1'b1;
                    dec_out.res0 = '{code_unit: unit_val, is_end: 1'b0};
                    units_next   = units_inc;
                    if (units_inc >= max_count || units_inc == 16'h0000) begin
                        dec_out.wr1  = 1'b1;
                        dec_out.res1 = '{code_unit: 16'h0000, is_end: 1'b1};
                        full_next    = 1'b1;
                        pend_next    = 2'd0;
                        partial_next = 16'h0000;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 2'd0;
            partial_reg <= 16'h0000;
            units_reg   <= 16'h0000;
            full_reg    <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            partial_reg <= partial_next;
            units_reg   <= units_next;
            full_reg    <= full_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_wr1_needs_wr0: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_out.wr1 |-> (dec_out.wr0 && !dec_out.res0.is_end && dec_out.res1.is_end))
        else $error("second result without a unit first");

    a_full_clears_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> (pend_reg == 2'd0 && partial_reg == 16'h0000))
        else $error("partial sequence kept after termination");

    a_term_sets_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && data_byte != 8'h00 && dec_out.wr1) |=> full_reg)
        else $error("forced terminator did not mark string full");
`endif

endmodule

### rtl/u8u16_result_fifo.sv
// Result queue: takes up to two results a cycle, delivers one a beat while m_ready is high.
module u8u16_result_fifo
    import u8u16_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dec_out_t    dec_out,
    output logic        space,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_is_end
);

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic [FIFO_AW-1:0]   wr_ptr_second;
    logic                 pop;

    assign pop           = m_valid && m_ready;
    assign m_valid       = (count_reg != '0);
    assign space         = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign m_code_unit   = mem_reg[rd_ptr_reg].code_unit;
    assign m_is_end      = mem_reg[rd_ptr_reg].is_end;
    assign wr_ptr_second = wr_ptr_reg + FIFO_AW'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(dec_out.wr0) + FIFO_AW'(dec_out.wr1);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(dec_out.wr0) + FIFO_CW'(dec_out.wr1)
                      - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < FIFO_DEPTH; i++) begin
            if (dec_out.wr0 && wr_ptr_reg == FIFO_AW'(i)) begin
                mem_reg[i] <= dec_out.res0;
            end else if (dec_out.wr1 && wr_ptr_second == FIFO_AW'(i)) begin
                mem_reg[i] <= dec_out.res1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_out.wr0 |-> space)
        else $error("results pushed without room");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !dec_out.wr0) |=> (count_reg == $past(count_reg) - FIFO_CW'(1)))
        else $error("queue count lost a beat");
`endif

endmodule

### rtl/utf8_to_utf16_decoder_top.sv
// Top level: input register, APB register file, decoder and result queue.
// Path: an accepted byte is held in the input register, decoded and written into the result queue.
// Throughput: one byte per cycle while the result queue has space; a unit that reaches
// the limit also queues its terminator, and the queue delivers one result per beat.
// Reset: aresetn, synchronous, active low; clears all string state and sets
// max_count to 65535.
module utf8_to_utf16_decoder_top
    import u8u16_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_code_unit,
    output logic              m_is_end,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [15:0] max_count_reg;
    logic        space;
    logic        fire;
    dec_out_t    dec_out;

    assign pready  = 1'b1;
    assign fire    = in_valid_reg && space;
    assign s_ready = !in_valid_reg || fire;
    assign prdata  = (paddr[2] == REG_MAX_COUNT) ? {16'h0000, max_count_reg} : 32'h0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_count_reg <= MAX_COUNT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_COUNT) begin
            max_count_reg <= pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    u8u16_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .data_byte (in_byte_reg),
        .max_count (max_count_reg),
        .dec_out   (dec_out)
    );

    u8u16_result_fifo u_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .dec_out     (dec_out),
        .space       (space),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code_unit (m_code_unit),
        .m_is_end    (m_is_end)
    );

endmodule
